// ===== rtl/bat_pkg.sv =====
// Shared types and constants for the block address translation lookup.
// Holds the sequencer state type, item codes and the field masks of a
// translation pair. No dependencies.
package bat_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } bat_state_t;

  typedef enum logic {
    ACT_TRANSLATE = 1'b0,
    ACT_WRITE     = 1'b1
  } bat_action_t;

  typedef enum logic [1:0] {
    PROT_NONE = 2'd0,
    PROT_RO   = 2'd1,
    PROT_RW   = 2'd2
  } bat_prot_t;

  localparam logic [31:0] BEPI_HI_MASK  = 32'hF000_0000;
  localparam logic [31:0] BEPI_LO_MASK  = 32'h0FFE_0000;
  localparam logic [31:0] BL_FIELD_MASK = 32'h0000_1FFC;
  localparam logic [31:0] PAGE_MASK     = 32'h0001_F000;
  localparam logic [31:0] VS_BIT        = 32'h0000_0002;
  localparam logic [31:0] VP_BIT        = 32'h0000_0001;
  localparam int unsigned BL_SHIFT      = 15;

  // Protection from the PP bits of a lower word.
  function automatic logic [1:0] prot_of(input logic [31:0] lower);
    logic [1:0] pp;
    pp = lower[1:0];
    case (pp)
      2'd0:    prot_of = PROT_NONE;
      2'd2:    prot_of = PROT_RW;
      default: prot_of = PROT_RO;
    endcase
  endfunction

endpackage

// ===== rtl/block_address_translation_lookup.sv =====
// Block address translation lookup: translation pair registers, entry scan
// sequencer and one shared compare unit. Depends on bat_pkg.
//
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    action, address, side, mode, write target
// out_      output     out_valid/out_ready  hit, physical_address, protection
//
// A write item stores its word on acceptance; the empty result then moves to the
// output register from the finishing state once that register is free.
// A translate item walks the entries of its side through the one compare unit,
// one entry a cycle, stopping at the first match or after the last entry.
// in_ready is high only while the sequencer is idle; a result waits in its own
// state while the output register is still full.
// Reset clears all translation words to zero and empties the output register.
module block_address_translation_lookup
  import bat_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [31:0] in_virtual_address,
  input  logic        in_is_instruction,
  input  logic        in_user_mode,
  input  logic [1:0]  in_entry_index,
  input  logic        in_lower_word,
  input  logic [31:0] in_write_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [31:0] out_physical_address,
  output logic [1:0]  out_protection
);

  localparam int unsigned IDX_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned ADDR_W = IDX_W + 1;
  localparam int unsigned DEPTH  = 2 * (2 ** IDX_W);

  // Words of both sides; entry i of a side sits at {side, i}.
  logic [31:0] upper_r [DEPTH];
  logic [31:0] lower_r [DEPTH];

  bat_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      va_r;
  logic             side_r;
  logic             user_r;

  logic             res_hit_r;
  logic [31:0]      res_pa_r;
  logic [1:0]       res_prot_r;

  logic             out_valid_r;
  logic             out_hit_r;
  logic [31:0]      out_pa_r;
  logic [1:0]       out_prot_r;

  logic             in_fire;
  logic             out_fire;
  logic             scan_en;
  logic             finish_en;
  logic             is_write;
  logic [3:0]       wr_idx_wide;
  logic             wr_ok;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  // Shared compare unit
  logic [31:0] up_w, lo_w, bl_w, vbit_w;
  logic        match_w;
  logic        last_w;
  logic [31:0] pa_w;

  assign in_fire     = in_valid & in_ready;
  assign out_fire    = out_valid_r & out_ready;
  assign is_write    = (in_action == ACT_WRITE);
  assign wr_idx_wide = {2'b00, in_entry_index};
  assign wr_ok       = (wr_idx_wide < 4'(NUM_ENTRIES));
  assign wr_addr     = {in_is_instruction, wr_idx_wide[IDX_W-1:0]};
  assign rd_addr     = {side_r, cnt_r};

  always_comb begin
    up_w    = upper_r[rd_addr];
    lo_w    = lower_r[rd_addr];
    bl_w    = (up_w & BL_FIELD_MASK) << BL_SHIFT;
    vbit_w  = user_r ? VP_BIT : VS_BIT;
    match_w = ((va_r & BEPI_HI_MASK) == (up_w & BEPI_HI_MASK)) &&
              (((va_r & BEPI_LO_MASK) & ~bl_w) == (up_w & BEPI_LO_MASK)) &&
              ((up_w & vbit_w) != 32'd0);
    pa_w    = (lo_w & BEPI_HI_MASK) | (va_r & BEPI_LO_MASK & bl_w) |
              (lo_w & BEPI_LO_MASK) | (va_r & PAGE_MASK);
    last_w  = (cnt_r == IDX_W'(NUM_ENTRIES - 1));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_fire) begin
          state_nxt = is_write ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match_w || last_w) begin
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    scan_en   = 1'b0;
    finish_en = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready  = 1'b1;
      ST_SCAN:   scan_en   = 1'b1;
      ST_FINISH: finish_en = !out_valid_r || out_ready;
      default:   in_ready  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < int'(DEPTH); i++) begin
        upper_r[i] <= '0;
        lower_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (in_fire && is_write && wr_ok) begin
        if (in_lower_word) begin
          lower_r[wr_addr] <= in_write_value;
        end else begin
          upper_r[wr_addr] <= in_write_value;
        end
      end
      if (finish_en) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      va_r       <= in_virtual_address;
      side_r     <= in_is_instruction;
      user_r     <= in_user_mode;
      // A write, or a scan that runs out of entries, reports an empty result.
      res_hit_r  <= 1'b0;
      res_pa_r   <= '0;
      res_prot_r <= PROT_NONE;
    end else if (scan_en && match_w) begin
      res_hit_r  <= 1'b1;
      res_pa_r   <= pa_w;
      res_prot_r <= prot_of(lo_w);
    end
    if (finish_en) begin
      out_hit_r  <= res_hit_r;
      out_pa_r   <= res_pa_r;
      out_prot_r <= res_prot_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hit              = out_hit_r;
  assign out_physical_address = out_pa_r;
  assign out_protection       = out_prot_r;

  // A new word is taken only when the sequencer is idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> state_r == ST_IDLE)
    else $error("input accepted while busy");

  // The scan counter never runs past the last entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> cnt_r <= IDX_W'(NUM_ENTRIES - 1))
    else $error("scan counter out of range");

  // A miss carries a zero address and no access.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |-> (out_pa_r == 32'd0 && out_prot_r == PROT_NONE))
    else $error("miss with non-empty payload");

  // Translated addresses are page aligned.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pa_r[11:0] == 12'd0)
    else $error("physical address not page aligned");

  // A finished result is never overwritten before it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_pa_r) &&
                                     $stable(out_hit_r)))
    else $error("pending result lost");

endmodule
